// File: rtl/cfbs_pkg.sv
`timescale 1ns / 1ps
// cfbs_pkg: sizes, opcodes, register indexes and control structs of the
// canvas framebuffer scaler; no dependencies

package cfbs_pkg;

  // canvas and physical raster geometry
  localparam int CANVAS_W = 128;
  localparam int CANVAS_H = 64;
  localparam int PHYS_W   = 320;
  localparam int PHYS_H   = 240;

  localparam int COLOR_W  = 16;
  localparam int DEPTH    = CANVAS_W * CANVAS_H;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int LX_W     = $clog2(CANVAS_W);
  localparam int LY_W     = $clog2(CANVAS_H);
  localparam int COL_W    = $clog2(PHYS_W);
  localparam int ROW_W    = $clog2(PHYS_H);

  // nearest-neighbour step: canvas advance per physical pixel, split into
  // whole part and remainder for the error accumulator
  localparam int LX_Q = CANVAS_W / PHYS_W;
  localparam int LX_R = CANVAS_W % PHYS_W;
  localparam int LY_Q = CANVAS_H / PHYS_H;
  localparam int LY_R = CANVAS_H % PHYS_H;

  // opcodes
  localparam logic [1:0] OP_MONO  = 2'd0;
  localparam logic [1:0] OP_COLOR = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_PIXEL = 2'd3;

  // configuration register indexes
  localparam logic REG_FORE = 1'b0;
  localparam logic REG_BACK = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_run;   // clearing sweep writes one entry this cycle
    logic clr_load;  // start a clear with the background colour
    logic wr_go;     // draw beat accepted
    logic pix_go;    // pixel beat accepted
  } cfbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // sweep is at the last entry
    logic pipe_room;  // read pipeline can take a pixel beat
  } cfbs_sts_t;

endpackage

// File: rtl/canvas_framebuffer_scaler_top.sv
`timescale 1ns / 1ps
// canvas_framebuffer_scaler_top: top level of the nearest-neighbour canvas
// scaler; instantiates cfbs_ctrl and cfbs_datapath, uses cfbs_pkg
//
// usage
// - input channel (in_valid/in_ready) carries one command beat: mono draw,
//   colour write, clear canvas, or emit next physical pixel
// - draw and colour write beats produce no result; positions outside the
//   128x64 canvas are dropped
// - a pixel beat produces one result beat on out_valid/out_ready through the
//   read stage and the output register; pixel beats can be accepted every cycle
//   while the read pipeline has room and no sweep is running
// - a clear beat sweeps the canvas memory one entry per cycle over all 8192
//   entries with in_ready low; results already in flight still drain
// - after reset the same sweep writes zero over the canvas (in_ready low);
//   cfg_we writes are taken throughout
// - when the receiver stalls, the read stage and output register hold up to
//   two results, then in_ready drops until out_ready returns
// - the scan runs 320x240 in raster order with row and frame end flags and
//   wraps to the top-left pixel after the last pixel of a frame

module canvas_framebuffer_scaler_top import cfbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // command beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_pos_x,
  input  logic [7:0]         in_pos_y,
  input  logic               in_pixel_on,
  input  logic [COLOR_W-1:0] in_pixel_value,
  // register writes
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [COLOR_W-1:0] cfg_wdata,
  // pixel beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COLOR_W-1:0] out_color,
  output logic               out_row_end,
  output logic               out_frame_end
);

  cfbs_cmd_t cmd;
  cfbs_sts_t sts;

  // sequencing of sweeps and the input handshake
  cfbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // memory, scan counters and result pipeline
  cfbs_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_on    (in_pixel_on),
    .in_pixel_value (in_pixel_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_color      (out_color),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end)
  );

  // no beat is taken while a sweep owns the memory write port
  assert property (@(posedge clk) disable iff (!rst_n) cmd.clr_run |-> !in_ready)
    else $error("input accepted during clearing sweep");

  // a clear beat blocks the very next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == OP_CLEAR)) |=> !in_ready)
    else $error("input still ready after clear beat");

  // the frame end always lands on a row end
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_row_end)
    else $error("frame end without row end");

  // a pixel beat is never taken without room in the read pipeline
  assert property (@(posedge clk) disable iff (!rst_n) cmd.pix_go |-> sts.pipe_room)
    else $error("pixel beat accepted with full pipeline");

endmodule

// File: rtl/cfbs_ctrl.sv
`timescale 1ns / 1ps
// cfbs_ctrl: controller of the canvas framebuffer scaler, sequences the
// clearing sweeps and gates the input handshake; uses cfbs_pkg

module cfbs_ctrl import cfbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_ready,
  input  cfbs_sts_t  sts,
  output cfbs_cmd_t  cmd
);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_RUN) && sts.pipe_room;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.clr_run  = (state_r == ST_INIT) || (state_r == ST_CLEAR);
    cmd.clr_load = accept && (in_opcode == OP_CLEAR);
    cmd.wr_go    = accept && ((in_opcode == OP_MONO) || (in_opcode == OP_COLOR));
    cmd.pix_go   = accept && (in_opcode == OP_PIXEL);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (sts.clr_last) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.clr_load) state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/cfbs_datapath.sv
`timescale 1ns / 1ps
// cfbs_datapath: canvas memory, colour registers, raster scan counters and
// the two-stage pixel read pipeline; uses cfbs_pkg

module cfbs_datapath import cfbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfbs_cmd_t          cmd,
  output cfbs_sts_t          sts,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_pos_x,
  input  logic [7:0]         in_pos_y,
  input  logic               in_pixel_on,
  input  logic [COLOR_W-1:0] in_pixel_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [COLOR_W-1:0] cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COLOR_W-1:0] out_color,
  output logic               out_row_end,
  output logic               out_frame_end
);

  logic [COLOR_W-1:0] canvas_mem [DEPTH];

  logic [COLOR_W-1:0] fore_r, back_r, fill_r;
  logic [ADDR_W-1:0]  clr_addr_r;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [LX_W-1:0]    lx_r, lx_nxt;
  logic [LY_W-1:0]    ly_r, ly_nxt;
  logic [COL_W-1:0]   lx_acc_r, lx_acc_nxt;
  logic [ROW_W-1:0]   ly_acc_r, ly_acc_nxt;
  logic [COL_W:0]     lx_sum;
  logic [ROW_W:0]     ly_sum;
  logic               last_col, last_row;

  logic               s1_valid_r;
  logic [COLOR_W-1:0] rd_data_r;
  logic               s1_row_end_r, s1_frame_end_r;
  logic               s1_move;

  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_row_end_r, out_frame_end_r;

  logic               in_range;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, wr_addr, rd_addr;
  logic [COLOR_W-1:0] mem_wdata, draw_color;

  // colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= {COLOR_W{1'b1}};
      back_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FORE) fore_r <= cfg_wdata;
      if (cfg_index == REG_BACK) back_r <= cfg_wdata;
    end
  end

  // clearing sweep, zero after reset and background on a clear beat
  assign sts.clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      fill_r     <= '0;
    end else if (cmd.clr_load) begin
      clr_addr_r <= '0;
      fill_r     <= back_r;
    end else if (cmd.clr_run) begin
      clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + ADDR_W'(1);
    end
  end

  // draw address and bounds
  assign in_range   = ({1'b0, in_pos_x} < 9'(CANVAS_W)) && ({1'b0, in_pos_y} < 9'(CANVAS_H));
  assign wr_addr    = ADDR_W'(in_pos_y) * ADDR_W'(CANVAS_W) + ADDR_W'(in_pos_x);
  assign draw_color = (in_opcode == OP_COLOR) ? in_pixel_value
                    : (in_pixel_on ? fore_r : back_r);

  assign mem_we    = cmd.clr_run || (cmd.wr_go && in_range);
  assign mem_waddr = cmd.clr_run ? clr_addr_r : wr_addr;
  assign mem_wdata = cmd.clr_run ? fill_r : draw_color;

  assign rd_addr = ADDR_W'(ly_r) * ADDR_W'(CANVAS_W) + ADDR_W'(lx_r);

  always_ff @(posedge clk) begin
    if (mem_we) canvas_mem[mem_waddr] <= mem_wdata;
    if (cmd.pix_go) rd_data_r <= canvas_mem[rd_addr];
  end

  // raster scan with error accumulators for the canvas coordinates
  assign last_col = (col_r == COL_W'(PHYS_W - 1));
  assign last_row = (row_r == ROW_W'(PHYS_H - 1));
  assign lx_sum   = {1'b0, lx_acc_r} + (COL_W + 1)'(LX_R);
  assign ly_sum   = {1'b0, ly_acc_r} + (ROW_W + 1)'(LY_R);

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    lx_nxt     = lx_r;
    ly_nxt     = ly_r;
    lx_acc_nxt = lx_acc_r;
    ly_acc_nxt = ly_acc_r;
    if (last_col) begin
      col_nxt    = '0;
      lx_nxt     = '0;
      lx_acc_nxt = '0;
      if (last_row) begin
        row_nxt    = '0;
        ly_nxt     = '0;
        ly_acc_nxt = '0;
      end else begin
        row_nxt = row_r + ROW_W'(1);
        if (ly_sum >= (ROW_W + 1)'(PHYS_H)) begin
          ly_acc_nxt = ROW_W'(ly_sum - (ROW_W + 1)'(PHYS_H));
          ly_nxt     = ly_r + LY_W'(LY_Q + 1);
        end else begin
          ly_acc_nxt = ROW_W'(ly_sum);
          ly_nxt     = ly_r + LY_W'(LY_Q);
        end
      end
    end else begin
      col_nxt = col_r + COL_W'(1);
      if (lx_sum >= (COL_W + 1)'(PHYS_W)) begin
        lx_acc_nxt = COL_W'(lx_sum - (COL_W + 1)'(PHYS_W));
        lx_nxt     = lx_r + LX_W'(LX_Q + 1);
      end else begin
        lx_acc_nxt = COL_W'(lx_sum);
        lx_nxt     = lx_r + LX_W'(LX_Q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      lx_r     <= '0;
      ly_r     <= '0;
      lx_acc_r <= '0;
      ly_acc_r <= '0;
    end else if (cmd.pix_go) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      lx_r     <= lx_nxt;
      ly_r     <= ly_nxt;
      lx_acc_r <= lx_acc_nxt;
      ly_acc_r <= ly_acc_nxt;
    end
  end

  // read stage then output register
  assign s1_move       = s1_valid_r && (!out_valid_r || out_ready);
  assign sts.pipe_room = !s1_valid_r || !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.pix_go) begin
      s1_row_end_r   <= last_col;
      s1_frame_end_r <= last_col && last_row;
    end
    if (s1_move) begin
      out_color_r     <= rd_data_r;
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pix_go)   s1_valid_r <= 1'b1;
      else if (s1_move) s1_valid_r <= 1'b0;
      if (s1_move)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_color     = out_color_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// File: tb/canvas_framebuffer_scaler_top_tb.sv
`timescale 1ns / 1ps
// canvas_framebuffer_scaler_top_tb: self-checking bench for the canvas scaler;
// drives command beats and register writes, predicts every pixel beat from a
// shadow canvas and scan position; needs cfbs_pkg and canvas_framebuffer_scaler_top

module canvas_framebuffer_scaler_top_tb;
  import cfbs_pkg::*;

  // generous bound: reset sweep, a handful of clear sweeps, the row scan
  // and the stalled phases fit several times over
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_REPORTS = 40;

  // one expected pixel beat
  typedef struct {
    logic [COLOR_W-1:0] color;
    logic               row_end;
    logic               frame_end;
  } scan_pixel_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode      = OP_MONO;
  logic [7:0]         in_pos_x       = '0;
  logic [7:0]         in_pos_y       = '0;
  logic               in_pixel_on    = 1'b0;
  logic [COLOR_W-1:0] in_pixel_value = '0;
  logic               cfg_we         = 1'b0;
  logic               cfg_index      = REG_FORE;
  logic [COLOR_W-1:0] cfg_wdata      = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [COLOR_W-1:0] out_color;
  logic               out_row_end;
  logic               out_frame_end;

  // shadow copy of the block: canvas, scan position and both colour registers
  logic [COLOR_W-1:0] shadow_canvas [DEPTH];
  int unsigned        shadow_col    = 0;
  int unsigned        shadow_row    = 0;
  logic [COLOR_W-1:0] fore_color_q  = 16'hFFFF;
  logic [COLOR_W-1:0] back_color_q  = 16'h0000;

  // pixel beats accepted on the input and not yet seen on the output
  scan_pixel_t pending_pixels [$];

  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int          hold_left      = 0;
  int          mismatch_count = 0;
  int unsigned sent_count     = 0;
  int unsigned cycle_count    = 0;

  canvas_framebuffer_scaler_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_on    (in_pixel_on),
    .in_pixel_value (in_pixel_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_color      (out_color),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end)
  );

  // 50 MHz clock
  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // canvas pixel that the next pixel beat will show (nearest neighbour, truncating)
  function automatic logic [7:0] shown_x();
    return 8'(shadow_col * CANVAS_W / PHYS_W);
  endfunction

  function automatic logic [7:0] shown_y();
    return 8'(shadow_row * CANVAS_H / PHYS_H);
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
               cycle_count, field, got, want);
  endtask

  // update the shadow state for one accepted command beat; a pixel beat also
  // queues the result it must produce
  task automatic apply_command(input logic [1:0] op, input logic [7:0] x,
                               input logic [7:0] y, input logic on,
                               input logic [COLOR_W-1:0] value);
    scan_pixel_t pix;
    bit          on_canvas;
    on_canvas = (x < CANVAS_W) && (y < CANVAS_H);
    case (op)
      OP_MONO: begin
        if (on_canvas)
          shadow_canvas[ADDR_W'(y * CANVAS_W + x)] = on ? fore_color_q : back_color_q;
      end
      OP_COLOR: begin
        if (on_canvas)
          shadow_canvas[ADDR_W'(y * CANVAS_W + x)] = value;
      end
      OP_CLEAR: begin
        foreach (shadow_canvas[i])
          shadow_canvas[i] = back_color_q;
      end
      OP_PIXEL: begin
        pix.color     = shadow_canvas[ADDR_W'(shown_y() * CANVAS_W + shown_x())];
        pix.row_end   = (shadow_col == PHYS_W - 1);
        pix.frame_end = pix.row_end && (shadow_row == PHYS_H - 1);
        pending_pixels.push_back(pix);
        // raster advance, wrapping to the top-left after the frame end
        if (pix.row_end) begin
          shadow_col = 0;
          shadow_row = pix.frame_end ? 0 : shadow_row + 1;
        end else begin
          shadow_col++;
        end
      end
    endcase
  endtask

  // offer one command beat; entered and left at a falling edge, valid stays
  // high on return so a following beat needs no second assignment
  task automatic send_command(input logic [1:0] op, input logic [7:0] x,
                              input logic [7:0] y, input logic on,
                              input logic [COLOR_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_pixel_on    <= on;
    in_pixel_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_command(op, x, y, on, value);
    sent_count++;
    @(negedge clk);
  endtask

  // pixel beat with junk in the fields it ignores
  task automatic send_pixel();
    send_command(OP_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
  endtask

  // mono draw or colour write at (x,y) with random colour content
  task automatic send_draw(input logic [7:0] x, input logic [7:0] y);
    send_command($urandom_range(1) ? OP_COLOR : OP_MONO, x, y,
                 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
  endtask

  // drop valid and wait until every queued pixel beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  // register writes only when idle: nothing in flight and no clear sweep
  // running, then a short pause for whatever the last draw beat left behind
  task automatic write_register(input logic idx, input logic [COLOR_W-1:0] data);
    wait_drained();
    while (!in_ready) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FORE)
      fore_color_q = data;
    else
      back_color_q = data;
  endtask

  // draw ops against the pixel the scan is about to show, plus off-canvas drops
  task automatic test_draw_ops();
    send_command(OP_COLOR, shown_x(), shown_y(), 1'b0, 16'hFFFF);
    send_command(OP_COLOR, 8'd255, shown_y(), 1'b1, 16'h0000);
    send_command(OP_COLOR, shown_x(), 8'd255, 1'b1, 16'h0000);
    send_pixel();
    send_command(OP_COLOR, shown_x(), shown_y(), 1'b1, 16'h0000);
    // one past both edges of the canvas
    send_command(OP_MONO, 8'(CANVAS_W), 8'(CANVAS_H), 1'b1, 16'hFFFF);
    send_pixel();
    send_command(OP_MONO, shown_x(), shown_y(), 1'b1, 16'h0000);
    send_pixel();
    send_command(OP_MONO, shown_x(), shown_y(), 1'b0, 16'hFFFF);
    send_pixel();
    // far corner of the canvas, the last entry of the memory
    send_command(OP_COLOR, 8'(CANVAS_W - 1), 8'(CANVAS_H - 1), 1'b0, 16'hA5A5);
  endtask

  // swapped register extremes for mono draws and clears
  task automatic test_register_colors();
    write_register(REG_FORE, 16'h0000);
    write_register(REG_BACK, 16'hFFFF);
    send_command(OP_MONO, shown_x(), shown_y(), 1'b1, 16'hFFFF);
    send_pixel();
    send_command(OP_MONO, shown_x(), shown_y(), 1'b0, 16'h0000);
    send_pixel();
    // clear ignores every other field; so does the pixel beat
    send_command(OP_CLEAR, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);
    send_command(OP_PIXEL, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);
    write_register(REG_BACK, 16'h0000);
    send_command(OP_CLEAR, 8'h00, 8'h00, 1'b0, 16'h0000);
    send_command(OP_PIXEL, 8'h00, 8'h00, 1'b0, 16'h0000);
  endtask

  // draw-then-show sequences make up the largest share, so that freshly written
  // pixels get read back right away; the rest is pixel runs, scattered draws,
  // clears and draws that fall just off the canvas
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int unsigned beats);
    int unsigned start;
    int unsigned pick;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    start = sent_count;
    while (sent_count - start < beats) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_draw(shown_x(), shown_y());
        repeat ($urandom_range(1, 4)) send_pixel();
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 8)) send_pixel();
      end else if (pick < 96) begin
        send_draw(8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (pick < 98) begin
        send_command(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
      end else begin
        send_draw(8'(shown_x() + CANVAS_W), shown_y());
        send_pixel();
      end
    end
  endtask

  // receiver holds off long enough for the block to fill and drop in_ready,
  // then the sender waits for every pixel beat before going on
  task automatic test_backpressure();
    wait_drained();
    hold_left = 300;
    repeat (12) send_pixel();
    wait_drained();
    repeat (6) send_pixel();
  endtask

  // scan through the rest of the current row and into the next one, with
  // scattered writes, so the row end and the column wrap get checked
  task automatic test_row_wrap();
    int unsigned beats;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    beats = PHYS_W - shadow_col + 7;
    repeat (beats) begin
      if ($urandom_range(7) == 0)
        send_draw(8'($urandom_range(CANVAS_W - 1)), 8'($urandom_range(CANVAS_H - 1)));
      send_pixel();
    end
  endtask

  // result side: random stalls, or a counted hold-off when one is requested
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // every pixel beat taken is compared with the oldest prediction
  always @(posedge clk) begin : result_check
    scan_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel beat with none expected, out_color", 32'(out_color), 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_color !== want.color)
          report_mismatch("out_color", 32'(out_color), 32'(want.color));
        if (out_row_end !== want.row_end)
          report_mismatch("out_row_end", 32'(out_row_end), 32'(want.row_end));
        if (out_frame_end !== want.frame_end)
          report_mismatch("out_frame_end", 32'(out_frame_end), 32'(want.frame_end));
      end
    end
  end

  // hang guard
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : run_tests
    foreach (shadow_canvas[i])
      shadow_canvas[i] = '0;
    // synchronous reset; the block then sweeps its canvas to zero with
    // in_ready low, which the first beat simply waits out
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_draw_ops();
    test_register_colors();

    // sender idles lightly, receiver heavily
    write_register(REG_FORE, 16'($urandom_range(16'hFFFF)));
    write_register(REG_BACK, 16'($urandom_range(16'hFFFF)));
    test_random_traffic(22, 72, 450);
    test_backpressure();

    // the other way round, registers back at their reset extremes
    write_register(REG_FORE, 16'hFFFF);
    write_register(REG_BACK, 16'h0000);
    test_random_traffic(72, 22, 450);

    // no idling on either side
    write_register(REG_FORE, 16'($urandom_range(16'hFFFF)));
    write_register(REG_BACK, 16'($urandom_range(16'hFFFF)));
    test_random_traffic(0, 0, 450);
    test_row_wrap();

    // let the last pixel beats drain, then a short tail for stray output
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
